FILE: design/hbp_pkg.sv
package hbp_pkg;

	// Request kinds on the input channel
	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_ENC   = 2'd1,
		KIND_FLUSH = 2'd2
	} kind_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_EMIT
	} st_t;

	localparam int BYTE_BITS       = 8;
	localparam int ACC_BITS        = 7;
	localparam int CODE_FIELD_BITS = 32;
	localparam int LEN_FIELD_BITS  = 6;
	localparam int SYM_FIELD_BITS  = 8;

endpackage

FILE: design/huffman_bit_packer.sv
// Huffman bit packer: the back end of a Huffman encoder. A load request
// writes one entry (code word and length) of a SYMBOL_COUNT-entry code
// table; lengths above min(MAX_CODE_LEN, 32) saturate and code bits above
// the length are dropped. An encode request looks its symbol up and shifts
// the code, most significant bit first, behind the pending bits; each full
// byte leaves on the output channel with earliest bit in bit 7, and the last
// byte of a request carries run_last. A flush with pending bits pads them
// with zeros at the low end and emits one byte with pad_bits set. Symbols
// with no code (never loaded, or loaded with length zero) and out-of-range
// symbols emit nothing. A load or flush is done when accepted; an encode
// reads the table through a registered read, then emits its full bytes, and
// no new request is taken until it is done. The output side takes one byte
// per cycle through a single output register and a stall there holds the
// block. The table resets to "no code" through per-entry valid flops, so no
// clearing pass follows reset and the block is ready at once.
module huffman_bit_packer #(
	parameter int MAX_CODE_LEN = 32,
	parameter int SYMBOL_COUNT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  symbol,
	input  logic [31:0] code_bits,
	input  logic [5:0]  code_len,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        run_last,
	output logic [2:0]  pad_bits
);

	// Stored code width: the smaller of the length limit and the code field
	localparam int LEN_LIM = (MAX_CODE_LEN < hbp_pkg::CODE_FIELD_BITS) ?
		MAX_CODE_LEN : hbp_pkg::CODE_FIELD_BITS;
	localparam int LEN_W   = $clog2(LEN_LIM + 1);
	localparam int ENT_W   = LEN_LIM + LEN_W;
	localparam int ADDR_W  = $clog2(SYMBOL_COUNT);
	localparam int WORK_W  = hbp_pkg::ACC_BITS + LEN_LIM;
	localparam int TOT_W   = $clog2(WORK_W + 1);

	localparam logic [hbp_pkg::LEN_FIELD_BITS-1:0] LEN_LIM_V =
		hbp_pkg::LEN_FIELD_BITS'(LEN_LIM);
	localparam logic [hbp_pkg::SYM_FIELD_BITS:0] SYM_LIMIT =
		(hbp_pkg::SYM_FIELD_BITS + 1)'(SYMBOL_COUNT);
	localparam logic [TOT_W-1:0] BYTE_T = TOT_W'(hbp_pkg::BYTE_BITS);

	hbp_pkg::st_t st_q, st_d;

	// Pending bits, right aligned, and their count
	logic [hbp_pkg::ACC_BITS-1:0] acc_q, acc_d;
	logic [2:0]                   cnt_q, cnt_d;
	logic                         acc_we;

	// Working word for the bytes of one encode request
	logic [WORK_W-1:0] work_q;
	logic [TOT_W-1:0]  tot_q;
	logic              work_we;

	// Code table valid bits: an entry never loaded has no code
	logic [SYMBOL_COUNT-1:0] vld_q;
	logic                    vld_s1;

	// Output register
	logic       out_valid_q;
	logic [7:0] out_byte_q, out_byte_d;
	logic       run_last_q, run_last_d;
	logic [2:0] pad_bits_q, pad_bits_d;
	logic       out_load, out_free;

	// Table port signals
	logic              tbl_we, tbl_re;
	logic [ADDR_W-1:0] tbl_addr;
	logic [ENT_W-1:0]  tbl_wdata, tbl_rdata;

	logic                              in_acc;
	logic                              sym_ok;
	logic [hbp_pkg::LEN_FIELD_BITS-1:0] len_sat;
	logic [LEN_LIM-1:0]                code_msk;
	logic [LEN_LIM-1:0]                rd_code;
	logic [LEN_W-1:0]                  rd_len;
	logic [WORK_W-1:0]                 work_d;
	logic [TOT_W-1:0]                  tot_d;
	logic [TOT_W-1:0]                  tot_rem;

	assign in_acc   = in_valid && in_ready;
	assign sym_ok   = {1'b0, symbol} < SYM_LIMIT;
	assign tbl_addr = symbol[ADDR_W-1:0];
	assign out_free = !out_valid_q || out_ready;

	// Saturate the length and drop code bits above it
	assign len_sat   = (code_len > LEN_LIM_V) ? LEN_LIM_V : code_len;
	assign code_msk  = code_bits[LEN_LIM-1:0] & ~({LEN_LIM{1'b1}} << len_sat);
	assign tbl_wdata = {code_msk, len_sat[LEN_W-1:0]};

	hbp_ram #(
		.WIDTH(ENT_W),
		.DEPTH(SYMBOL_COUNT)
	) u_table (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(tbl_addr),
		.wdata(tbl_wdata),
		.re   (tbl_re),
		.raddr(tbl_addr),
		.rdata(tbl_rdata)
	);

	// An entry that was never loaded reads as length zero
	assign rd_code = tbl_rdata[ENT_W-1:LEN_W];
	assign rd_len  = vld_s1 ? tbl_rdata[LEN_W-1:0] : '0;

	// Append the code behind the pending bits
	assign work_d  = (WORK_W'(acc_q) << rd_len) | WORK_W'(rd_code);
	assign tot_d   = TOT_W'(cnt_q) + TOT_W'(rd_len);
	assign tot_rem = tot_q - BYTE_T;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= hbp_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d       = st_q;
		in_ready   = 1'b0;
		tbl_we     = 1'b0;
		tbl_re     = 1'b0;
		acc_we     = 1'b0;
		acc_d      = acc_q;
		cnt_d      = cnt_q;
		work_we    = 1'b0;
		out_load   = 1'b0;
		out_byte_d = 8'(work_q >> (tot_q - BYTE_T));
		run_last_d = 1'b0;
		pad_bits_d = 3'd0;
		unique case (st_q)
			hbp_pkg::ST_IDLE: begin
				in_ready = out_free;
				if (in_acc) begin
					case (kind)
						hbp_pkg::KIND_LOAD: begin
							tbl_we = sym_ok;
						end
						hbp_pkg::KIND_ENC: begin
							if (sym_ok) begin
								tbl_re = 1'b1;
								st_d   = hbp_pkg::ST_LOOKUP;
							end
						end
						hbp_pkg::KIND_FLUSH: begin
							// Pad the pending bits at the low end
							if (cnt_q != 3'd0) begin
								pad_bits_d = 3'd0 - cnt_q;
								out_byte_d = {1'b0, acc_q} << pad_bits_d;
								run_last_d = 1'b1;
								out_load   = 1'b1;
								acc_we     = 1'b1;
								acc_d      = '0;
								cnt_d      = 3'd0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			hbp_pkg::ST_LOOKUP: begin
				if (rd_len == '0) begin
					st_d = hbp_pkg::ST_IDLE;
				end else if (tot_d < BYTE_T) begin
					// No full byte yet: just hold the new bits
					acc_we = 1'b1;
					acc_d  = work_d[hbp_pkg::ACC_BITS-1:0];
					cnt_d  = tot_d[2:0];
					st_d   = hbp_pkg::ST_IDLE;
				end else begin
					work_we = 1'b1;
					st_d    = hbp_pkg::ST_EMIT;
				end
			end
			hbp_pkg::ST_EMIT: begin
				// Advance one byte per cycle while the output register is free
				if (out_free) begin
					out_load = 1'b1;
					if (tot_rem < BYTE_T) begin
						run_last_d = 1'b1;
						acc_we     = 1'b1;
						acc_d      = work_q[hbp_pkg::ACC_BITS-1:0] &
							~({hbp_pkg::ACC_BITS{1'b1}} << tot_rem[2:0]);
						cnt_d      = tot_rem[2:0];
						st_d       = hbp_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				st_d = hbp_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			cnt_q       <= 3'd0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc_we) begin
				acc_q <= acc_d;
				cnt_q <= cnt_d;
			end
			if (tbl_we) begin
				vld_q[tbl_addr] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (tbl_re) begin
			vld_s1 <= vld_q[tbl_addr];
		end
		if (work_we) begin
			work_q <= work_d;
			tot_q  <= tot_d;
		end else if ((st_q == hbp_pkg::ST_EMIT) && out_free) begin
			tot_q <= tot_rem;
		end
		if (out_load) begin
			out_byte_q <= out_byte_d;
			run_last_q <= run_last_d;
			pad_bits_q <= pad_bits_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;
	assign pad_bits  = pad_bits_q;

endmodule

FILE: design/hbp_ram.sv
module hbp_ram #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: test/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Block configuration under test; the packer's own defaults.
	localparam int MAX_LEN = 32;
	localparam int SYMBOLS = 256;
	// Loaded lengths saturate to the smaller of the parameter and the code field width.
	localparam int LEN_CAP = (MAX_LEN < hbp_pkg::CODE_FIELD_BITS) ?
		MAX_LEN : hbp_pkg::CODE_FIELD_BITS;

	// Kind 3 has no member in the package; the block must ignore it.
	localparam logic [1:0] KIND_SPARE = 2'd3;

	localparam int RANDOM_REQS  = 415;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SHOW_MAX     = 10;
	localparam int EXP_DEPTH    = 4096;
	localparam int DIR_DEPTH    = 32;

	// One byte on the output channel.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic [2:0] pad;
	} packed_byte_t;

	// One request on the input channel, with optional hand-written expectation.
	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         sym;
		logic [31:0]        bits;
		logic [5:0]         len;
		logic               typed;
		logic [2:0]         n_typed;
		packed_byte_t [3:0] exp;
	} pack_req_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  kind;
	logic [7:0]  symbol;
	logic [31:0] code_bits;
	logic [5:0]  code_len;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        run_last;
	logic [2:0]  pad_bits;

	// Shadow copy of the code table and of the partial-byte accumulator.
	logic [31:0] shadow_code [SYMBOLS];
	logic [5:0]  shadow_len [SYMBOLS];
	logic [6:0]  shadow_acc;
	logic [2:0]  shadow_cnt;

	// Expected bytes in order, written at exp_wr and read at exp_rd.
	packed_byte_t exp_mem [EXP_DEPTH];
	int           exp_wr = 0;
	int           exp_rd = 0;

	// Directed rows in order.
	pack_req_t dir_mem [DIR_DEPTH];
	int        dir_count = 0;

	// Idle control shared by the two sides.
	bit quiet    = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int ready_hold = 0;

	int fails = 0;
	int bytes_seen = 0;
	int reqs_sent = 0;
	int loads_sent = 0;
	int flushes_sent = 0;
	int cycle_count = 0;

	huffman_bit_packer #(
		.MAX_CODE_LEN(MAX_LEN),
		.SYMBOL_COUNT(SYMBOLS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.symbol    (symbol),
		.code_bits (code_bits),
		.code_len  (code_len),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.pad_bits  (pad_bits)
	);

	always #10 clk = ~clk;

	// Work out the bytes one request produces and advance the shadow state.
	function automatic int pack_bytes(input pack_req_t r, output packed_byte_t [3:0] res);
		logic [5:0]  eff_len;
		logic [63:0] work;
		logic [7:0]  fbyte;
		int          total;
		int          n;
		res = '0;
		n = 0;
		case (r.kind)
			hbp_pkg::KIND_LOAD: begin
				// Saturate the length, then drop code bits above it.
				eff_len = (r.len > LEN_CAP) ? 6'(LEN_CAP) : r.len;
				if (int'(r.sym) < SYMBOLS) begin
					shadow_code[r.sym] = 32'(64'(r.bits) & ((64'd1 << eff_len) - 64'd1));
					shadow_len[r.sym] = eff_len;
				end
			end
			hbp_pkg::KIND_ENC: begin
				// Append the code behind the pending bits; peel off full bytes MSB first.
				if (int'(r.sym) < SYMBOLS && shadow_len[r.sym] != 0) begin
					work = (64'(shadow_acc) << shadow_len[r.sym]) | 64'(shadow_code[r.sym]);
					total = int'(shadow_cnt) + int'(shadow_len[r.sym]);
					while (total >= hbp_pkg::BYTE_BITS) begin
						total -= hbp_pkg::BYTE_BITS;
						res[n].data = 8'(work >> total);
						n++;
					end
					if (n > 0)
						res[n - 1].last = 1'b1;
					shadow_acc = 7'(work & ((64'd1 << total) - 64'd1));
					shadow_cnt = 3'(total);
				end
			end
			hbp_pkg::KIND_FLUSH: begin
				// Pad the leftover bits with zeros at the low end.
				if (shadow_cnt != 0) begin
					fbyte = {1'b0, shadow_acc};
					fbyte = fbyte << (hbp_pkg::BYTE_BITS - int'(shadow_cnt));
					res[0].data = fbyte;
					res[0].last = 1'b1;
					res[0].pad = 3'(hbp_pkg::BYTE_BITS - int'(shadow_cnt));
					n = 1;
					shadow_acc = '0;
					shadow_cnt = '0;
				end
			end
			default: begin
			end
		endcase
		return n;
	endfunction

	// Mostly short gaps, now and then a long one; none inside a quiet window.
	function automatic int idle_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Append one row to the directed table.
	function automatic void add_row(input pack_req_t r);
		dir_mem[dir_count] = r;
		dir_count++;
	endfunction

	// Directed row checked against the shadow state.
	function automatic void plain_row(input logic [1:0] k, input logic [7:0] s,
			input logic [31:0] b, input logic [5:0] l);
		pack_req_t r;
		r = '0;
		r.kind = k;
		r.sym = s;
		r.bits = b;
		r.len = l;
		add_row(r);
	endfunction

	// Directed row with bytes written out by hand; last marks the n-th byte.
	function automatic void typed_row(input logic [1:0] k, input logic [7:0] s,
			input logic [31:0] b, input logic [5:0] l, input int n, input logic [2:0] pad,
			input logic [7:0] d0, input logic [7:0] d1, input logic [7:0] d2,
			input logic [7:0] d3);
		pack_req_t r;
		r = '0;
		r.kind = k;
		r.sym = s;
		r.bits = b;
		r.len = l;
		r.typed = 1'b1;
		r.n_typed = 3'(n);
		r.exp[0].data = d0;
		r.exp[1].data = d1;
		r.exp[2].data = d2;
		r.exp[3].data = d3;
		r.exp[0].pad = pad;
		if (n > 0)
			r.exp[n - 1].last = 1'b1;
		add_row(r);
	endfunction

	// Random request: loads and encodes mostly over a small hot set of symbols, some flushes.
	function automatic pack_req_t random_req();
		pack_req_t r;
		int        pick;
		r = '0;
		pick = $urandom_range(0, 99);
		if (pick < 20)
			r.kind = hbp_pkg::KIND_LOAD;
		else if (pick < 83)
			r.kind = hbp_pkg::KIND_ENC;
		else if (pick < 95)
			r.kind = hbp_pkg::KIND_FLUSH;
		else
			r.kind = KIND_SPARE;
		if ($urandom_range(0, 99) < 70)
			r.sym = 8'($urandom_range(0, 15));
		else
			r.sym = 8'($urandom_range(0, 255));
		r.bits = $urandom();
		pick = $urandom_range(0, 99);
		if (pick < 5)
			r.len = '0;
		else if (pick < 15)
			r.len = 6'($urandom_range(33, 63));
		else if (pick < 35)
			r.len = 6'($urandom_range(17, 32));
		else
			r.len = 6'($urandom_range(1, 16));
		return r;
	endfunction

	// Offer one request; hold it until accepted, then predict its bytes.
	task automatic offer(input pack_req_t r);
		packed_byte_t [3:0] res;
		int                 n;
		int                 gap;
		int                 i;
		in_valid <= 1'b1;
		kind <= r.kind;
		symbol <= r.sym;
		code_bits <= r.bits;
		code_len <= r.len;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n = pack_bytes(r, res);
		// Hand-written rows still advance the shadow state, but their bytes win.
		if (r.typed) begin
			n = int'(r.n_typed);
			res = r.exp;
		end
		for (i = 0; i < n; i++) begin
			exp_mem[exp_wr] = res[i];
			exp_wr++;
		end
		reqs_sent++;
		if (r.kind == hbp_pkg::KIND_LOAD)
			loads_sent++;
		if (r.kind == hbp_pkg::KIND_FLUSH)
			flushes_sent++;
		gap = idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Compare one accepted byte with the oldest expectation.
	task automatic check_byte();
		packed_byte_t got;
		packed_byte_t want;
		got = {out_byte, run_last, pad_bits};
		bytes_seen++;
		if (exp_rd == exp_wr) begin
			fails++;
			if (fails <= SHOW_MAX)
				$display("[%0t] unexpected byte %h last %b pad %0d",
					$realtime, got.data, got.last, got.pad);
		end else begin
			want = exp_mem[exp_rd];
			exp_rd++;
			if (got.data !== want.data || got.last !== want.last || got.pad !== want.pad) begin
				fails++;
				if (fails <= SHOW_MAX)
					$display("[%0t] byte mismatch: expected %h last %b pad %0d, ",
						$realtime, want.data, want.last, want.pad,
						"got %h last %b pad %0d", got.data, got.last, got.pad);
			end
		end
	endtask

	// Receiver: check every accepted byte and drive out_ready with random stalls.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_byte();
			// Start the long hold-off once when asked; the sender keeps pushing meanwhile.
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				ready_hold = HOLD_CYCLES;
			end
			if (ready_hold > 0) begin
				ready_hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 2) == 0)
					ready_hold = idle_gap();
			end
		end
	end

	// Watchdog: end the run if it hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("cycle limit of %0d reached with %0d bytes outstanding",
				CYCLE_LIMIT, exp_wr - exp_rd);
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin : stimulus
		pack_req_t r;
		int        done;
		int        i;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = '0;
		symbol = '0;
		code_bits = '0;
		code_len = '0;
		for (i = 0; i < SYMBOLS; i++) begin
			shadow_code[i] = '0;
			shadow_len[i] = '0;
		end
		shadow_acc = '0;
		shadow_cnt = '0;

		// After reset every symbol has no code, and nothing is pending.
		typed_row(hbp_pkg::KIND_ENC, 8'd0, 32'h0, 6'd0, 0, 3'd0,
			8'h00, 8'h00, 8'h00, 8'h00);
		typed_row(hbp_pkg::KIND_FLUSH, 8'd0, 32'h0, 6'd0, 0, 3'd0,
			8'h00, 8'h00, 8'h00, 8'h00);
		// Unused kind with every field at its top: drop it.
		typed_row(KIND_SPARE, 8'hFF, 32'hFFFF_FFFF, 6'h3F, 0, 3'd0,
			8'h00, 8'h00, 8'h00, 8'h00);
		// Longest code at the top index: four full bytes of ones.
		typed_row(hbp_pkg::KIND_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32, 0, 3'd0,
			8'h00, 8'h00, 8'h00, 8'h00);
		typed_row(hbp_pkg::KIND_ENC, 8'hFF, 32'h0, 6'd0, 4, 3'd0,
			8'hFF, 8'hFF, 8'hFF, 8'hFF);
		// Length above the limit saturates.
		typed_row(hbp_pkg::KIND_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd63, 0, 3'd0,
			8'h00, 8'h00, 8'h00, 8'h00);
		plain_row(hbp_pkg::KIND_ENC, 8'd0, 32'h0, 6'd0);
		// Code bits above the length are dropped; flush pads three ones with five zeros.
		typed_row(hbp_pkg::KIND_LOAD, 8'd1, 32'hFFFF_FFFF, 6'd3, 0, 3'd0,
			8'h00, 8'h00, 8'h00, 8'h00);
		typed_row(hbp_pkg::KIND_ENC, 8'd1, 32'h0, 6'd0, 0, 3'd0,
			8'h00, 8'h00, 8'h00, 8'h00);
		typed_row(hbp_pkg::KIND_FLUSH, 8'd0, 32'h0, 6'd0, 1, 3'd5,
			8'hE0, 8'h00, 8'h00, 8'h00);
		// Loaded with length zero: still no code.
		typed_row(hbp_pkg::KIND_LOAD, 8'd2, 32'hDEAD_BEEF, 6'd0, 0, 3'd0,
			8'h00, 8'h00, 8'h00, 8'h00);
		typed_row(hbp_pkg::KIND_ENC, 8'd2, 32'h0, 6'd0, 0, 3'd0,
			8'h00, 8'h00, 8'h00, 8'h00);
		// Unaligned packing across byte boundaries.
		plain_row(hbp_pkg::KIND_LOAD, 8'd3, 32'h0000_0001, 6'd1);
		plain_row(hbp_pkg::KIND_LOAD, 8'd4, 32'h1234_5678, 6'd32);
		plain_row(hbp_pkg::KIND_ENC, 8'd1, 32'h0, 6'd0);
		plain_row(hbp_pkg::KIND_ENC, 8'd4, 32'h0, 6'd0);
		plain_row(hbp_pkg::KIND_ENC, 8'd3, 32'h0, 6'd0);
		plain_row(hbp_pkg::KIND_ENC, 8'd3, 32'h0, 6'd0);
		plain_row(hbp_pkg::KIND_ENC, 8'd3, 32'h0, 6'd0);
		plain_row(hbp_pkg::KIND_FLUSH, 8'd0, 32'h0, 6'd0);
		// Byte-aligned code on an empty accumulator passes straight through.
		plain_row(hbp_pkg::KIND_LOAD, 8'd5, 32'h0000_00A5, 6'd8);
		typed_row(hbp_pkg::KIND_ENC, 8'd5, 32'h0, 6'd0, 1, 3'd0,
			8'hA5, 8'h00, 8'h00, 8'h00);
		plain_row(hbp_pkg::KIND_LOAD, 8'd6, 32'h0000_0000, 6'd32);
		plain_row(hbp_pkg::KIND_ENC, 8'd6, 32'h0, 6'd0);
		plain_row(hbp_pkg::KIND_LOAD, 8'd7, 32'h8000_0001, 6'd33);
		plain_row(hbp_pkg::KIND_ENC, 8'd7, 32'h0, 6'd0);

		// Hold reset, then release it at a clock edge.
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < dir_count; i++)
			offer(dir_mem[i]);

		// Random part; requests of the unused kind do not count.
		done = 0;
		while (done < RANDOM_REQS) begin
			r = random_req();
			if (r.kind != KIND_SPARE) begin
				done++;
				case (done)
					// Back up the output: stall the receiver while the sender rushes.
					100: begin
						quiet <= 1'b1;
						hold_req <= 1'b1;
					end
					140: quiet <= 1'b0;
					// Drain completely before going on.
					250: begin
						in_valid <= 1'b0;
						@(posedge clk);
						while (exp_rd != exp_wr)
							@(posedge clk);
					end
					// Stretch with no idling on either side.
					300: quiet <= 1'b1;
					360: quiet <= 1'b0;
					default: begin
					end
				endcase
			end
			offer(r);
		end

		// Drop valid, wait for every byte, then give the block time to misbehave.
		in_valid <= 1'b0;
		@(posedge clk);
		while (exp_rd != exp_wr)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d requests (%0d loads, %0d flushes), checked %0d packed bytes",
			reqs_sent, loads_sent, flushes_sent, bytes_seen);
		$display("covered saturation, masked codes, empty entries, output backpressure");
		if (fails == 0) begin
			$display("testbench OK");
		end else begin
			$display("%0d failures", fails);
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
